### rtl/servo_motion_ramp_regulator_macros.svh
// Assertion macros shared by the servo ramp regulator RTL.
`ifndef SERVO_MOTION_RAMP_REGULATOR_MACROS_SVH
`define SERVO_MOTION_RAMP_REGULATOR_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SMRR_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMRR_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/smrr_pkg.sv
// Types and constants of the servo ramp regulator.
`timescale 1ns / 1ps
`default_nettype none

package smrr_pkg;

   localparam int MAX_SERVOS_DEFAULT = 16;
   localparam int ID_W    = 4;
   localparam int ID_SPAN = 16;

   // operation codes
   localparam logic OP_SET  = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // status codes
   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_STALL  = 2'd2;

   // register indexes
   localparam logic CSR_SLICE     = 1'b0;
   localparam logic CSR_STOP_MASK = 1'b1;

   localparam logic [9:0]  SLICE_RESET   = 10'd120;
   localparam logic [9:0]  MOVE_LEAD     = 10'd5;
   localparam logic [15:0] POS_INVALID   = 16'hFFFF;
   localparam logic [15:0] POS_MAX       = 16'd36000;
   localparam logic [16:0] COEF_ONE      = 17'h10000;
   localparam logic [15:0] STALL_DIST    = 16'd300;
   localparam logic [15:0] STALL_BACKOFF = 16'd200;
   localparam logic [2:0]  STALL_LIMIT   = 3'd5;
   localparam logic [7:0]  SPEED_MAX     = 8'd240;
   localparam logic [7:0]  SPEED_MIN     = 8'd1;

   // speed * coef^2 * slice fits in 50 bits; limit = (product >> 32) / 10
   localparam int PROD_W    = 50;
   localparam int FRAC_W    = 32;
   localparam int QUO_W     = PROD_W - FRAC_W;
   localparam logic [4:0] DIV_BY = 5'd10;
   localparam logic [4:0] DIV_STEPS = 5'(QUO_W);

   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [16:0]       mplier_type;

   typedef struct packed {
      logic        op;
      logic [3:0]  servo_id;
      logic [15:0] target_centideg;
      logic [7:0]  speed_tenths;
      logic [15:0] raise_q16;
      logic [10:0] measured_raw;
      logic        measured_valid;
   } req_type;

   typedef struct packed {
      logic [3:0]  out_servo_id;
      logic        out_op;
      logic        moved;
      logic [15:0] position_centideg;
      logic [9:0]  move_time_ms;
      logic [1:0]  status;
   } rsp_type;

endpackage

`default_nettype wire

### rtl/servo_motion_ramp_regulator.sv
// Servo ramp regulator: per-servo goal/ramp state and bit-serial step computation.
`timescale 1ns / 1ps
`default_nettype none
`include "servo_motion_ramp_regulator_macros.svh"

// A beat is taken when start is high and busy is low; every beat gives exactly
// one result beat, shown on rsp_data for the single cycle rsp_valid is high.
// The receiver cannot stall, so the result must be captured on that cycle.
// Set beats, out-of-range servos and ticks that do not move are evaluated in
// S_EVAL and then strobed from the result register. A tick that moves runs a
// shift-add multiplier one multiplier bit per cycle (ramp rate * slice unless
// the ramp is already full, then coef^2, then * speed, then * slice) and a
// restoring divide by ten, one quotient bit per cycle over 18 bits, then steps
// the position in S_STEP. busy is high from the accepting edge until the
// strobe; the next beat may be accepted while the strobe is up.
// Configuration writes land at once and must only be issued while busy is low
// and no result is pending. Ids at or beyond MAX_SERVOS echo id and op, rest zero.
module servo_motion_ramp_regulator #(
   parameter int MAX_SERVOS = smrr_pkg::MAX_SERVOS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // command side
   input  wire logic             start,
   output logic                  busy,
   input  wire smrr_pkg::req_type req_data,
   // result side
   output logic                  rsp_valid,
   output smrr_pkg::rsp_type     rsp_data,
   // register writes
   input  wire logic             csr_we,
   input  wire logic             csr_index,
   input  wire logic [15:0]      csr_wdata
);

   // only the first 16 servos can be addressed by a 4-bit id
   localparam int DEPTH = (MAX_SERVOS < smrr_pkg::ID_SPAN) ? MAX_SERVOS : smrr_pkg::ID_SPAN;
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [smrr_pkg::ID_W:0] DEPTH_V = (smrr_pkg::ID_W + 1)'(DEPTH);

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_EVAL  = 8'b0000_0010,
      S_MRATE = 8'b0000_0100,
      S_MSQ   = 8'b0000_1000,
      S_MSPD  = 8'b0001_0000,
      S_MSLC  = 8'b0010_0000,
      S_DIV   = 8'b0100_0000,
      S_STEP  = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   // config
   logic [9:0]  slice_ff;
   logic [15:0] stop_mask_ff;

   // per-servo state
   logic [15:0] position_now_ff  [DEPTH];
   logic [15:0] position_goal_ff [DEPTH];
   logic [16:0] ramp_coef_ff     [DEPTH];
   logic [7:0]  speed_goal_ff    [DEPTH];
   logic [15:0] ramp_rate_ff     [DEPTH];
   logic [2:0]  stall_count_ff   [DEPTH];

   // item and datapath
   smrr_pkg::req_type    req_ff, req_in;
   smrr_pkg::rsp_type    rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           stat_ff, stat_in;
   smrr_pkg::prod_type   acc_ff, acc_in;
   smrr_pkg::prod_type   mcand_ff, mcand_in;
   smrr_pkg::mplier_type mplier_ff, mplier_in;
   logic [smrr_pkg::QUO_W-1:0] quo_ff, quo_in;
   logic [3:0]           rem_ff, rem_in;
   logic [4:0]           cnt_ff, cnt_in;

   // store write controls
   logic        now_we, goal_we, coef_we, set_we, stall_we;
   logic [15:0] now_wd, goal_wd;
   logic [16:0] coef_wd;
   logic [2:0]  stall_wd;

   // decode of the held item
   logic             in_range;
   logic [IDX_W-1:0] idx;
   logic [15:0] now_rd, goal_rd;
   logic [16:0] coef_rd;
   logic [15:0] meas, meas_c, tgt_c;
   logic [7:0]  spd_c;
   logic        now_inv;

   // set path
   logic        adopt, rejected, upd, rev;
   logic [15:0] now_e, goal_e;

   // stall path
   logic        stall_en, meas_gt, big, trip;
   logic [15:0] ad, g_c, goal_eff;
   logic [16:0] g_up;
   logic [2:0]  cnt_inc;

   // arithmetic helpers
   logic [26:0] coef_sum;
   logic [16:0] coef_cap;
   smrr_pkg::prod_type mul_add;
   logic [4:0]  div_r;
   logic        div_ge;
   logic [15:0] gap, step, step1, now_next;
   logic [9:0]  mtime;

   assign in_range = {1'b0, req_ff.servo_id} < DEPTH_V;
   assign idx      = in_range ? req_ff.servo_id[IDX_W-1:0] : '0;
   assign now_rd   = position_now_ff[idx];
   assign goal_rd  = position_goal_ff[idx];
   assign coef_rd  = ramp_coef_ff[idx];
   assign now_inv  = now_rd == smrr_pkg::POS_INVALID;

   // raw * 24 = raw * 16 + raw * 8
   assign meas   = 16'({req_ff.measured_raw, 4'b0}) + 16'({req_ff.measured_raw, 3'b0});
   assign meas_c = (meas > smrr_pkg::POS_MAX) ? smrr_pkg::POS_MAX : meas;
   assign tgt_c  = (req_ff.target_centideg > smrr_pkg::POS_MAX) ? smrr_pkg::POS_MAX
                                                                 : req_ff.target_centideg;
   assign spd_c  = (req_ff.speed_tenths < smrr_pkg::SPEED_MIN) ? smrr_pkg::SPEED_MIN :
                   (req_ff.speed_tenths > smrr_pkg::SPEED_MAX) ? smrr_pkg::SPEED_MAX :
                   req_ff.speed_tenths;

   // set: adopt the measurement if the position is unknown, then retarget
   assign adopt    = now_inv && req_ff.measured_valid;
   assign rejected = now_inv && !req_ff.measured_valid;
   assign now_e    = now_inv ? meas_c : now_rd;
   assign goal_e   = now_inv ? meas_c : goal_rd;
   assign upd      = !rejected && (now_e != tgt_c);
   assign rev      = (now_e > goal_e) != (now_e > tgt_c);

   // tick: stall detection against feedback
   assign stall_en = stop_mask_ff[req_ff.servo_id] && req_ff.measured_valid && !now_inv;
   assign meas_gt  = meas > now_rd;
   assign ad       = meas_gt ? (meas - now_rd) : (now_rd - meas);
   assign big      = ad > smrr_pkg::STALL_DIST;
   assign cnt_inc  = stall_count_ff[idx] + 3'd1;
   assign trip     = big && (cnt_inc > smrr_pkg::STALL_LIMIT);
   assign g_up     = {1'b0, meas} + {1'b0, smrr_pkg::STALL_BACKOFF};
   // back off toward the commanded side of the measurement
   assign g_c      = meas_gt ? ((meas < smrr_pkg::STALL_BACKOFF) ? 16'd0
                                                                 : meas - smrr_pkg::STALL_BACKOFF)
                             : ((g_up > {1'b0, smrr_pkg::POS_MAX}) ? smrr_pkg::POS_MAX
                                                                   : g_up[15:0]);
   assign goal_eff = (stall_en && trip) ? g_c : goal_rd;

   // coef + rate * slice, capped at one
   assign coef_sum = {10'd0, coef_rd} + acc_ff[26:0];
   assign coef_cap = (coef_sum > {10'd0, smrr_pkg::COEF_ONE}) ? smrr_pkg::COEF_ONE
                                                              : coef_sum[16:0];
   assign mul_add  = acc_ff + (mplier_ff[0] ? mcand_ff : '0);

   // restoring divide by ten, one quotient bit per cycle
   assign div_r  = {rem_ff, quo_ff[smrr_pkg::QUO_W-1]};
   assign div_ge = div_r >= smrr_pkg::DIV_BY;

   // step = max(1, min(|goal - now|, limit))
   assign gap      = (goal_rd > now_rd) ? (goal_rd - now_rd) : (now_rd - goal_rd);
   assign step     = ({2'b0, gap} > quo_ff) ? quo_ff[15:0] : gap;
   assign step1    = (step == 16'd0) ? 16'd1 : step;
   assign now_next = (goal_rd < now_rd) ? (now_rd - step1) : (now_rd + step1);
   assign mtime    = (slice_ff >= smrr_pkg::MOVE_LEAD) ? (slice_ff - smrr_pkg::MOVE_LEAD)
                                                      : 10'd0;

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = 1'b0;
      stat_in      = stat_ff;
      acc_in       = acc_ff;
      mcand_in     = mcand_ff;
      mplier_in    = mplier_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      cnt_in       = cnt_ff;
      now_we       = 1'b0;
      goal_we      = 1'b0;
      coef_we      = 1'b0;
      set_we       = 1'b0;
      stall_we     = 1'b0;
      now_wd       = meas_c;
      goal_wd      = meas_c;
      coef_wd      = '0;
      stall_wd     = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_data;
               state_in = S_EVAL;
            end
         end

         S_EVAL: begin
            rsp_in.out_servo_id      = req_ff.servo_id;
            rsp_in.out_op            = req_ff.op;
            rsp_in.moved             = 1'b0;
            rsp_in.position_centideg = '0;
            rsp_in.move_time_ms      = '0;
            rsp_in.status            = smrr_pkg::STATUS_OK;
            acc_in                   = '0;
            if (!in_range) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else if (req_ff.op == smrr_pkg::OP_SET) begin
               now_we   = adopt;
               goal_we  = adopt || upd;
               goal_wd  = upd ? tgt_c : meas_c;
               coef_we  = upd && rev;
               set_we   = upd;
               rsp_in.position_centideg = adopt ? meas_c : now_rd;
               rsp_in.status = rejected ? smrr_pkg::STATUS_REJECT : smrr_pkg::STATUS_OK;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end else begin
               stall_we = stall_en;
               stall_wd = (big && !trip) ? cnt_inc : 3'd0;
               goal_we  = stall_en && trip;
               goal_wd  = g_c;
               stat_in  = (stall_en && trip) ? smrr_pkg::STATUS_STALL : smrr_pkg::STATUS_OK;
               if (now_rd == goal_eff) begin
                  rsp_in.position_centideg = now_rd;
                  rsp_in.status            = stat_in;
                  rsp_valid_in             = 1'b1;
                  state_in                 = S_IDLE;
               end else if (coef_rd[16]) begin
                  // already at full ramp
                  mcand_in  = smrr_pkg::prod_type'(smrr_pkg::COEF_ONE);
                  mplier_in = smrr_pkg::COEF_ONE;
                  state_in  = S_MSQ;
               end else begin
                  mcand_in  = smrr_pkg::prod_type'(ramp_rate_ff[idx]);
                  mplier_in = smrr_pkg::mplier_type'(slice_ff);
                  state_in  = S_MRATE;
               end
            end
         end

         S_MRATE: begin
            if (mplier_ff == '0) begin
               coef_we   = 1'b1;
               coef_wd   = coef_cap;
               acc_in    = '0;
               mcand_in  = smrr_pkg::prod_type'(coef_cap);
               mplier_in = coef_cap;
               state_in  = S_MSQ;
            end else begin
               acc_in    = mul_add;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end

         S_MSQ: begin
            if (mplier_ff == '0) begin
               acc_in    = '0;
               mcand_in  = acc_ff;
               mplier_in = smrr_pkg::mplier_type'(speed_goal_ff[idx]);
               state_in  = S_MSPD;
            end else begin
               acc_in    = mul_add;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end

         S_MSPD: begin
            if (mplier_ff == '0) begin
               acc_in    = '0;
               mcand_in  = acc_ff;
               mplier_in = smrr_pkg::mplier_type'(slice_ff);
               state_in  = S_MSLC;
            end else begin
               acc_in    = mul_add;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end

         S_MSLC: begin
            if (mplier_ff == '0) begin
               quo_in   = acc_ff[smrr_pkg::PROD_W-1:smrr_pkg::FRAC_W];
               rem_in   = '0;
               cnt_in   = smrr_pkg::DIV_STEPS;
               state_in = S_DIV;
            end else begin
               acc_in    = mul_add;
               mcand_in  = mcand_ff << 1;
               mplier_in = mplier_ff >> 1;
            end
         end

         S_DIV: begin
            rem_in = div_ge ? 4'(div_r - smrr_pkg::DIV_BY) : div_r[3:0];
            quo_in = {quo_ff[smrr_pkg::QUO_W-2:0], div_ge};
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == 5'd1) begin
               state_in = S_STEP;
            end
         end

         S_STEP: begin
            now_we  = 1'b1;
            now_wd  = now_next;
            coef_we = now_next == goal_rd;
            rsp_in.moved             = 1'b1;
            rsp_in.position_centideg = now_next;
            rsp_in.move_time_ms      = mtime;
            rsp_in.status            = stat_ff;
            rsp_valid_in             = 1'b1;
            state_in                 = S_IDLE;
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         slice_ff     <= smrr_pkg::SLICE_RESET;
         stop_mask_ff <= '0;
         for (int i = 0; i < DEPTH; i++) begin
            position_now_ff[i]  <= smrr_pkg::POS_INVALID;
            position_goal_ff[i] <= smrr_pkg::POS_INVALID;
            ramp_coef_ff[i]     <= '0;
            speed_goal_ff[i]    <= '0;
            ramp_rate_ff[i]     <= '0;
            stall_count_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               smrr_pkg::CSR_SLICE:     slice_ff     <= csr_wdata[9:0];
               smrr_pkg::CSR_STOP_MASK: stop_mask_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (now_we) begin
            position_now_ff[idx] <= now_wd;
         end
         if (goal_we) begin
            position_goal_ff[idx] <= goal_wd;
         end
         if (coef_we) begin
            ramp_coef_ff[idx] <= coef_wd;
         end
         if (set_we) begin
            speed_goal_ff[idx] <= spd_c;
            ramp_rate_ff[idx]  <= req_ff.raise_q16;
         end
         if (stall_we) begin
            stall_count_ff[idx] <= stall_wd;
         end
      end
   end

   // payload and datapath, no reset needed
   always_ff @(posedge clock) begin
      req_ff    <= req_in;
      rsp_ff    <= rsp_in;
      stat_ff   <= stat_in;
      acc_ff    <= acc_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      cnt_ff    <= cnt_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `SMRR_ASSERT_IMP(a_rsp_after_work, clock, reset, rsp_valid, $past(busy), "result without work")
   `SMRR_ASSERT_NEXT(a_one_strobe, clock, reset, rsp_valid, !rsp_valid, "back-to-back strobes")
   `SMRR_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy, "accept did not go busy")
   `SMRR_ASSERT_IMP(a_move_tick, clock, reset, rsp_valid && rsp_data.moved, (rsp_data.out_op == smrr_pkg::OP_TICK) && (rsp_data.position_centideg <= smrr_pkg::POS_MAX), "bad move result")
   `SMRR_ASSERT_IMP(a_div_rem, clock, reset, state_ff == S_DIV, {1'b0, rem_ff} < smrr_pkg::DIV_BY, "divider remainder out of range")

endmodule

`default_nettype wire

### verif/servo_ramp_checker.sv
// Checker for the servo ramp regulator: tracks servo state and compares every result beat.
`timescale 1ns / 1ps

module servo_ramp_checker (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic              busy,
   input  wire smrr_pkg::req_type req_data,
   input  wire logic              rsp_valid,
   input  wire smrr_pkg::rsp_type rsp_data,
   input  wire logic              csr_we,
   input  wire logic              csr_index,
   input  wire logic [15:0]       csr_wdata,
   output int                     error_count,
   output int                     outstanding
);

   localparam int SERVOS = 16;

   // register copies
   logic [9:0]  slice_ms_cfg;
   logic [15:0] stop_mask_cfg;

   // per-servo motion state
   logic [15:0] pos_now   [SERVOS];
   logic [15:0] pos_goal  [SERVOS];
   logic [16:0] ramp_coef [SERVOS];
   logic [7:0]  spd_goal  [SERVOS];
   logic [15:0] ramp_rate [SERVOS];
   logic [2:0]  stall_cnt [SERVOS];

   smrr_pkg::rsp_type due_results[$];
   int                fails = 0;

   // Applies one command beat to the servo state; returns the result it must produce.
   function automatic smrr_pkg::rsp_type advance_servo(smrr_pkg::req_type beat);
      smrr_pkg::rsp_type res;
      int unsigned       id, meas, tgt, spd, cur, goal;
      int                diff, mag, backoff;
      longint unsigned   coef, reach, span;
      res = '0;
      id = 32'(beat.servo_id);
      meas = 32'(beat.measured_raw) * 32'd24;
      res.out_servo_id = beat.servo_id;
      res.out_op = beat.op;
      res.status = smrr_pkg::STATUS_OK;
      if (beat.op == smrr_pkg::OP_SET) begin
         tgt = (beat.target_centideg > smrr_pkg::POS_MAX) ? 32'(smrr_pkg::POS_MAX)
                                                          : 32'(beat.target_centideg);
         spd = 32'(beat.speed_tenths);
         if (spd < smrr_pkg::SPEED_MIN) spd = 32'(smrr_pkg::SPEED_MIN);
         if (spd > smrr_pkg::SPEED_MAX) spd = 32'(smrr_pkg::SPEED_MAX);
         if (pos_now[id] == smrr_pkg::POS_INVALID) begin
            if (!beat.measured_valid) begin
               res.status = smrr_pkg::STATUS_REJECT;
            end else begin
               // adopt the measurement as both position and goal
               pos_now[id] = (meas > smrr_pkg::POS_MAX) ? smrr_pkg::POS_MAX : 16'(meas);
               pos_goal[id] = pos_now[id];
            end
         end
         if (res.status == smrr_pkg::STATUS_OK && pos_now[id] != tgt) begin
            // direction flip restarts the ramp
            if ((pos_now[id] > pos_goal[id]) != (pos_now[id] > tgt)) ramp_coef[id] = '0;
            pos_goal[id] = 16'(tgt);
            spd_goal[id] = 8'(spd);
            ramp_rate[id] = beat.raise_q16;
         end
      end else begin
         if (stop_mask_cfg[id] && beat.measured_valid &&
             pos_now[id] != smrr_pkg::POS_INVALID) begin
            diff = int'(meas) - int'(pos_now[id]);
            mag = (diff < 0) ? -diff : diff;
            if (mag > int'(smrr_pkg::STALL_DIST)) begin
               stall_cnt[id] = stall_cnt[id] + 3'd1;
               if (stall_cnt[id] > smrr_pkg::STALL_LIMIT) begin
                  backoff = (diff > 0) ? int'(meas) - int'(smrr_pkg::STALL_BACKOFF)
                                       : int'(meas) + int'(smrr_pkg::STALL_BACKOFF);
                  if (backoff < 0) backoff = 0;
                  if (backoff > int'(smrr_pkg::POS_MAX)) backoff = int'(smrr_pkg::POS_MAX);
                  pos_goal[id] = 16'(backoff);
                  stall_cnt[id] = '0;
                  res.status = smrr_pkg::STATUS_STALL;
               end
            end else begin
               stall_cnt[id] = '0;
            end
         end
         if (pos_now[id] != pos_goal[id]) begin
            cur = 32'(pos_now[id]);
            goal = 32'(pos_goal[id]);
            coef = 64'(ramp_coef[id]);
            if (coef < smrr_pkg::COEF_ONE) begin
               coef = coef + 64'(ramp_rate[id]) * 64'(slice_ms_cfg);
               if (coef > smrr_pkg::COEF_ONE) coef = 64'(smrr_pkg::COEF_ONE);
               ramp_coef[id] = 17'(coef);
            end else begin
               coef = 64'(smrr_pkg::COEF_ONE);
            end
            // speed is in tenths, coef is Q16 squared
            reach = (64'(spd_goal[id]) * coef * coef * 64'(slice_ms_cfg)) / (64'd10 << 32);
            span = (goal > cur) ? 64'(goal - cur) : 64'(cur - goal);
            if (reach < span) span = reach;
            if (span < 1) span = 1;
            if (goal < cur) cur = cur - 32'(span);
            else cur = cur + 32'(span);
            if (cur == goal) ramp_coef[id] = '0;
            pos_now[id] = 16'(cur);
            res.moved = 1'b1;
            res.move_time_ms = (slice_ms_cfg >= smrr_pkg::MOVE_LEAD)
                               ? slice_ms_cfg - smrr_pkg::MOVE_LEAD : '0;
         end
      end
      res.position_centideg = pos_now[id];
      return res;
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      smrr_pkg::rsp_type want;
      if (reset) begin
         slice_ms_cfg = smrr_pkg::SLICE_RESET;
         stop_mask_cfg = '0;
         for (int i = 0; i < SERVOS; i++) begin
            pos_now[i] = smrr_pkg::POS_INVALID;
            pos_goal[i] = smrr_pkg::POS_INVALID;
            ramp_coef[i] = '0;
            spd_goal[i] = '0;
            ramp_rate[i] = '0;
            stall_cnt[i] = '0;
         end
         due_results.delete();
      end else begin
         if (csr_we) begin
            if (csr_index == smrr_pkg::CSR_SLICE) slice_ms_cfg = csr_wdata[9:0];
            else stop_mask_cfg = csr_wdata;
         end
         if (rsp_valid) begin
            if (due_results.size() == 0) begin
               $error("result beat with nothing expected: servo %0d op %0d pos %0d",
                      rsp_data.out_servo_id, rsp_data.out_op, rsp_data.position_centideg);
               fails++;
            end else begin
               want = due_results.pop_front();
               check_field("out_servo_id", 32'(want.out_servo_id), 32'(rsp_data.out_servo_id));
               check_field("out_op", 32'(want.out_op), 32'(rsp_data.out_op));
               check_field("moved", 32'(want.moved), 32'(rsp_data.moved));
               check_field("position_centideg", 32'(want.position_centideg),
                           32'(rsp_data.position_centideg));
               check_field("move_time_ms", 32'(want.move_time_ms),
                           32'(rsp_data.move_time_ms));
               check_field("status", 32'(want.status), 32'(rsp_data.status));
            end
         end
         if (start && !busy) due_results.push_back(advance_servo(req_data));
      end
      error_count <= fails;
      outstanding <= due_results.size();
   end

endmodule

### verif/testbench.sv
// Top of the servo ramp regulator testbench: clock, reset, command stimulus and verdict.
`timescale 1ns / 1ps

module testbench;

   localparam int IDLE_LIMIT    = 2000;  // cycles without any beat or write
   localparam int RANDOM_PHASES = 7;
   localparam int PHASE_BEATS   = 100;
   localparam int TAIL_CYCLES   = 100;   // longer than the slowest tick
   localparam int REQ_W         = $bits(smrr_pkg::req_type);

   // slice and auto-stop settings per random phase; extremes included
   localparam logic [15:0] PHASE_SLICE [RANDOM_PHASES] =
      '{16'd120, 16'd1023, 16'd5, 16'd0, 16'hFFFF, 16'd4, 16'd250};
   localparam logic [15:0] PHASE_MASK [RANDOM_PHASES] =
      '{16'h0000, 16'hFFFF, 16'h000F, 16'h0000, 16'h0005, 16'hFFFF, 16'h0000};

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   smrr_pkg::req_type req_data = '0;
   logic              csr_we = 1'b0;
   logic              csr_index = smrr_pkg::CSR_SLICE;
   logic [15:0]       csr_wdata = '0;

   logic              busy;
   logic              rsp_valid;
   smrr_pkg::rsp_type rsp_data;
   int                fail_count;
   int                outstanding;

   // last position each servo reported; feeds measured values that track motion
   logic [15:0] seen_pos [16] = '{default: smrr_pkg::POS_INVALID};

   servo_motion_ramp_regulator i_dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   servo_ramp_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .error_count (fail_count),
      .outstanding (outstanding)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (rsp_valid && rsp_data.position_centideg <= smrr_pkg::POS_MAX)
         seen_pos[rsp_data.out_servo_id] <= rsp_data.position_centideg;
   end

   // Watchdog: a run that stops moving beats is a failure.
   initial begin : watchdog
      int idle;
      idle = 0;
      while (idle < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_valid || csr_we) idle = 0;
         else idle++;
      end
      $display("testbench: FAIL");
      $finish;
   end

   function automatic smrr_pkg::req_type mk_beat(logic op, int id, int tgt, int spd,
                                                 int raise, int raw, logic valid);
      smrr_pkg::req_type b;
      b.op = op;
      b.servo_id = 4'(id);
      b.target_centideg = 16'(tgt);
      b.speed_tenths = 8'(spd);
      b.raise_q16 = 16'(raise);
      b.measured_raw = 11'(raw);
      b.measured_valid = valid;
      return b;
   endfunction

   // Mostly well-formed traffic on a few hot servos: goals, then ticks whose
   // measured value follows the reported position; the rest is noise.
   function automatic smrr_pkg::req_type random_beat();
      smrr_pkg::req_type b;
      int unsigned       pick, sel;
      int                known, raw;
      b = REQ_W'({$urandom, $urandom});
      b.servo_id = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(0, 3))
                                               : 4'($urandom_range(0, 15));
      b.measured_valid = ($urandom_range(0, 9) != 0);
      known = int'(seen_pos[b.servo_id]);
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
         b.op = smrr_pkg::OP_SET;
         sel = $urandom_range(0, 9);
         if (sel == 0 && known <= smrr_pkg::POS_MAX) b.target_centideg = 16'(known);
         else if (sel == 1) b.target_centideg = 16'($urandom_range(36001, 65535));
         else if (sel == 2)
            b.target_centideg = $urandom_range(0, 1) ? smrr_pkg::POS_MAX : 16'd0;
         else if (sel <= 5 && known <= smrr_pkg::POS_MAX)
            b.target_centideg = 16'($urandom_range(known > 600 ? known - 600 : 0,
                                                   known + 600 > 36000 ? 36000 : known + 600));
         else b.target_centideg = 16'($urandom_range(0, 36000));
         sel = $urandom_range(0, 3);
         if (sel == 0) b.raise_q16 = 16'($urandom_range(0, 255));
         else if (sel >= 2) b.raise_q16 = 16'($urandom_range(8192, 65535));
      end else if (pick < 90) begin
         b.op = smrr_pkg::OP_TICK;
         if (known <= smrr_pkg::POS_MAX && $urandom_range(0, 3) != 0) begin
            // servo roughly where it was told to be
            raw = known / 24 + int'($urandom_range(0, 4)) - 2;
            b.measured_raw = 11'((raw < 0) ? 0 : raw);
         end
      end
      return b;
   endfunction

   // Beat is offered until taken; start stays up for a following beat.
   task automatic send_beat(input smrr_pkg::req_type beat);
      start <= 1'b1;
      req_data <= beat;
      do @(posedge clock); while (busy);
   endtask

   task automatic pause(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Hold off until every result is back and the block is idle.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0 || busy);
   endtask

   task automatic write_reg(input logic index, input logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   initial begin : stimulus
      int          beats, burst, sel;
      logic [15:0] slice_val, mask_val;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // --- directed: reset settings (slice 120, auto-stop off) ---
      send_beat(mk_beat(smrr_pkg::OP_SET, 0, 1000, 10, 100, 0, 1'b0));  // no position: reject
      send_beat(mk_beat(smrr_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b0));       // both invalid: idle
      // adopt saturated, goal same
      send_beat(mk_beat(smrr_pkg::OP_SET, 0, 65535, 255, 65535, 2047, 1'b1));
      send_beat(mk_beat(smrr_pkg::OP_SET, 0, 0, 0, 0, 0, 1'b1));        // slowest, no ramp
      send_beat(mk_beat(smrr_pkg::OP_TICK, 0, 0, 0, 0, 0, 1'b1));       // minimum step of one
      send_beat(mk_beat(smrr_pkg::OP_SET, 1, 36000, 240, 65535, 0, 1'b1));  // adopt zero
      repeat (3) send_beat(mk_beat(smrr_pkg::OP_TICK, 1, 0, 0, 0, 0, 1'b1));
      send_beat(mk_beat(smrr_pkg::OP_SET, 1, 0, 240, 65535, 0, 1'b1));  // reversal clears ramp
      send_beat(mk_beat(smrr_pkg::OP_TICK, 1, 0, 0, 0, 0, 1'b1));
      send_beat(mk_beat(smrr_pkg::OP_SET, 15, 20000, 128, 255, 1024, 1'b1));
      send_beat(mk_beat(smrr_pkg::OP_TICK, 15, 0, 0, 0, 0, 1'b1));

      // --- directed: stall detection, longest slice ---
      drain();
      write_reg(smrr_pkg::CSR_STOP_MASK, 16'hFFFF);
      write_reg(smrr_pkg::CSR_SLICE, 16'd1023);
      send_beat(mk_beat(smrr_pkg::OP_SET, 2, 30000, 240, 65535, 500, 1'b1));
      // sixth one retargets
      repeat (6) send_beat(mk_beat(smrr_pkg::OP_TICK, 2, 0, 0, 0, 0, 1'b1));
      send_beat(mk_beat(smrr_pkg::OP_TICK, 2, 0, 0, 0, 2047, 1'b1));
      send_beat(mk_beat(smrr_pkg::OP_TICK, 2, 0, 0, 0, 2047, 1'b0));

      // --- directed: short slices give no move time ---
      drain();
      write_reg(smrr_pkg::CSR_SLICE, 16'd0);
      send_beat(mk_beat(smrr_pkg::OP_SET, 3, 500, 240, 65535, 0, 1'b1));
      send_beat(mk_beat(smrr_pkg::OP_TICK, 3, 0, 0, 0, 0, 1'b1));
      drain();
      write_reg(smrr_pkg::CSR_SLICE, 16'd4);
      send_beat(mk_beat(smrr_pkg::OP_TICK, 3, 0, 0, 0, 0, 1'b1));
      drain();
      write_reg(smrr_pkg::CSR_SLICE, 16'd5);
      send_beat(mk_beat(smrr_pkg::OP_TICK, 3, 0, 0, 0, 0, 1'b1));

      // --- random phases, each with its own settings, drained in between ---
      for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
         drain();
         slice_val = (ph == RANDOM_PHASES - 1) ? 16'($urandom) : PHASE_SLICE[ph];
         mask_val = (ph == 3) ? 16'($urandom) : PHASE_MASK[ph];
         write_reg(smrr_pkg::CSR_SLICE, slice_val);
         write_reg(smrr_pkg::CSR_STOP_MASK, mask_val);
         beats = 0;
         while (beats < PHASE_BEATS) begin
            burst = $urandom_range(1, 24);
            repeat (burst) begin
               send_beat(random_beat());
               beats++;
            end
            sel = $urandom_range(0, 3);
            if (sel == 1) pause($urandom_range(1, 4));
            else if (sel == 2) pause($urandom_range(1, 90));
            else if (sel == 3) pause($urandom_range(1, 30));
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && outstanding == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule

### sim.f
+incdir+rtl
rtl/smrr_pkg.sv
rtl/servo_motion_ramp_regulator.sv
verif/servo_ramp_checker.sv
verif/testbench.sv
